// File: rtl/core/tea_pkg.sv
// ----------------------------------------------------------------------------
// tea_pkg
// Shared types, constants and the mixing function of the TEA block cipher.
// ----------------------------------------------------------------------------
package tea_pkg;

    localparam int unsigned TEA_WORD_W   = 32;
    localparam int unsigned TEA_CYCLES   = 32;
    // One half-round (one word update) per pipeline stage.
    localparam int unsigned TEA_STAGES   = 2 * TEA_CYCLES;
    localparam int unsigned TEA_CFG_IDX_W = 8;

    localparam logic [TEA_WORD_W-1:0] TEA_DELTA = 32'h9e37_79b9;

    // Mode codes
    localparam logic MODE_ENC = 1'b0;
    localparam logic MODE_DEC = 1'b1;

    // Configuration register indexes
    localparam logic [TEA_CFG_IDX_W-1:0] REG_KEY0 = 8'd0;
    localparam logic [TEA_CFG_IDX_W-1:0] REG_KEY1 = 8'd1;
    localparam logic [TEA_CFG_IDX_W-1:0] REG_KEY2 = 8'd2;
    localparam logic [TEA_CFG_IDX_W-1:0] REG_KEY3 = 8'd3;

    typedef logic [TEA_WORD_W-1:0] t_tea_word;

    typedef struct packed {
        t_tea_word k0;
        t_tea_word k1;
        t_tea_word k2;
        t_tea_word k3;
    } t_tea_key;

    typedef struct packed {
        logic      mode;
        t_tea_word a;
        t_tea_word b;
    } t_tea_lane;

    // k * delta mod 2^32; elaboration-time only.
    function automatic t_tea_word tea_round_sum(input int unsigned k);
        logic [63:0] prod;
        prod = 64'(k) * 64'(TEA_DELTA);
        return prod[TEA_WORD_W-1:0];
    endfunction

    // ((x<<4)+ka) ^ (x+s) ^ ((x>>5)+kb), wrapping
    function automatic t_tea_word tea_mix(input t_tea_word x, input t_tea_word s,
                                          input t_tea_word ka, input t_tea_word kb);
        return ((x << 4) + ka) ^ (x + s) ^ ((x >> 5) + kb);
    endfunction

endpackage

// File: rtl/core/tea_if.sv
// ----------------------------------------------------------------------------
// tea_if
// Valid/ready channels of the TEA block: block in, block out, key writes.
// ----------------------------------------------------------------------------
interface tea_in_if;
    import tea_pkg::*;
    logic      valid;
    logic      ready;
    logic      mode;
    t_tea_word first_word;
    t_tea_word second_word;

    modport source (output valid, output mode, output first_word,
                    output second_word, input ready);
    modport sink   (input valid, input mode, input first_word,
                    input second_word, output ready);
endinterface

interface tea_out_if;
    import tea_pkg::*;
    logic      valid;
    logic      ready;
    t_tea_word out_first_word;
    t_tea_word out_second_word;

    modport source (output valid, output out_first_word, output out_second_word,
                    input ready);
    modport sink   (input valid, input out_first_word, input out_second_word,
                    output ready);
endinterface

interface tea_cfg_if;
    import tea_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [TEA_CFG_IDX_W-1:0] index;
    t_tea_word                data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/core/tea_key_file.sv
// ----------------------------------------------------------------------------
// tea_key_file
// Holds the four 32-bit words of the 128-bit key, written through the config
// channel.
// ----------------------------------------------------------------------------
module tea_key_file (
    input  logic              i_clk,
    input  logic              i_rst_n,
    tea_cfg_if.sink           i_cfg,
    output tea_pkg::t_tea_key o_key
);
    import tea_pkg::*;

    t_tea_key r_key;
    t_tea_key n_key;

    assign i_cfg.ready = 1'b1;

    always_comb begin
        n_key = r_key;
        if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_KEY0: n_key.k0 = i_cfg.data;
                REG_KEY1: n_key.k1 = i_cfg.data;
                REG_KEY2: n_key.k2 = i_cfg.data;
                REG_KEY3: n_key.k3 = i_cfg.data;
                default:  n_key = r_key;   // out-of-range index ignored
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= '0;
        end else begin
            r_key <= n_key;
        end
    end

    assign o_key = r_key;

endmodule

// File: rtl/core/tea_stage.sv
// ----------------------------------------------------------------------------
// tea_stage
// One pipeline stage: a single TEA half-round, registered.
// ----------------------------------------------------------------------------
module tea_stage #(
    parameter int unsigned STAGE = 0
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  tea_pkg::t_tea_lane i_lane,
    input  tea_pkg::t_tea_key  i_key,
    output logic               o_valid,
    output tea_pkg::t_tea_lane o_lane
);
    import tea_pkg::*;

    localparam int unsigned CYC  = STAGE / 2;
    localparam logic        HALF = 1'(STAGE % 2);
    // Encrypt cycle n uses (n+1)*delta; decrypt cycle n uses (32-n)*delta.
    localparam t_tea_word   ENC_SUM = tea_round_sum(CYC + 1);
    localparam t_tea_word   DEC_SUM = tea_round_sum(TEA_CYCLES - CYC);

    logic      upd_a;
    t_tea_word x;
    t_tea_word s;
    t_tea_word ka;
    t_tea_word kb;
    t_tea_word mix;
    t_tea_word tgt;
    t_tea_word res;

    logic      r_valid;
    t_tea_lane r_lane;
    t_tea_lane n_lane;

    // Encrypt: first half updates a, second updates b. Decrypt is reversed.
    assign upd_a = (i_lane.mode == HALF);

    always_comb begin
        x   = upd_a ? i_lane.b : i_lane.a;
        ka  = upd_a ? i_key.k0 : i_key.k2;
        kb  = upd_a ? i_key.k1 : i_key.k3;
        s   = (i_lane.mode == MODE_DEC) ? DEC_SUM : ENC_SUM;
        mix = tea_mix(x, s, ka, kb);
        tgt = upd_a ? i_lane.a : i_lane.b;
        res = (i_lane.mode == MODE_DEC) ? (tgt - mix) : (tgt + mix);
        n_lane = i_lane;
        if (upd_a) begin
            n_lane.a = res;
        end else begin
            n_lane.b = res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lane <= n_lane;
        end
    end

    assign o_valid = r_valid;
    assign o_lane  = r_lane;

endmodule

// File: rtl/core/tea_block_cipher.sv
// ----------------------------------------------------------------------------
// tea_block_cipher
// TEA encrypt/decrypt (TEA_CYCLES rounds), fully unrolled into a half-round pipeline.
// ----------------------------------------------------------------------------
// Each accepted request passes through every half-round stage register in
//   order; the last stage register is the output register.
// Throughput: one block per cycle while the sink takes results.
// Reset (sync, active low): all stage valid bits cleared, key words zeroed.
// Key writes take effect on the next cycle; write keys only while idle.
// ----------------------------------------------------------------------------
module tea_block_cipher (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tea_in_if.sink     i_in,
    tea_out_if.source  o_out,
    tea_cfg_if.sink    i_cfg
);
    import tea_pkg::*;

    localparam int unsigned NST = TEA_STAGES;

    t_tea_key  key;
    logic      en;                 // global advance; whole pipe stalls together
    logic      [NST:0] vld;        // vld[k+1]: valid out of stage k, vld[0] = input
    t_tea_lane lane [NST+1];

    // ---- key registers ----
    tea_key_file u_keys (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_key   (key)
    );

    // ---- flow control ----
    // Pipe moves whenever the output slot is empty or being drained.
    assign en         = !vld[NST] || o_out.ready;
    assign i_in.ready = en;

    // ---- stage 0 feed ----
    assign vld[0]       = i_in.valid;
    assign lane[0].mode = i_in.mode;
    assign lane[0].a    = i_in.first_word;
    assign lane[0].b    = i_in.second_word;

    // ---- half-round pipeline ----
    for (genvar g = 0; g < NST; g++) begin : g_stage
        tea_stage #(
            .STAGE (g)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (vld[g]),
            .i_lane  (lane[g]),
            .i_key   (key),
            .o_valid (vld[g+1]),
            .o_lane  (lane[g+1])
        );
    end

    // ---- output ----
    assign o_out.valid           = vld[NST];
    assign o_out.out_first_word  = lane[NST].a;
    assign o_out.out_second_word = lane[NST].b;

    // ---- assertions ----
    // Reset empties the pipeline.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !(|vld[NST:1]))
        else $error("pipeline valid bits not cleared by reset");

    // Valid bits shift one stage per advance.
    a_valid_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        en |=> (vld[NST:1] == $past(vld[NST-1:0])))
        else $error("valid bits did not shift with the pipeline");

    // While stalled nothing moves inside the pipe.
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(vld[NST:1]))
        else $error("pipeline valid bits changed during stall");

    // Input back-pressure only comes from a waiting result.
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (o_out.valid && !o_out.ready))
        else $error("input stalled without a pending output");

endmodule

// File: test/tea_block_cipher_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tea_block_cipher_test
// Self-checking bench for the TEA block cipher. Blocks are pushed through the
// valid/ready channels under random stalls on both sides. A scoreboard runs
// its own TEA encrypt/decrypt over all TEA_CYCLES rounds on each accepted request, under the key
// last written, and compares every returned block in order.
// ----------------------------------------------------------------------------
module tea_block_cipher_test;
    import tea_pkg::*;

    localparam int          CLK_HALF       = 10;
    localparam int          RANDOM_BLOCKS  = 800;
    localparam int          CHUNKS         = 12;      // key changes in the random part
    localparam int          WATCHDOG_LIMIT = 4000;    // cycles with no handshake at all
    localparam int          DRAIN_TAIL     = TEA_STAGES + 16;
    localparam int          MAX_REPORTS    = 200;
    localparam t_tea_word   DEC_SUM_START  = 32'hC6EF_3720;   // 32 * delta mod 2^32

    typedef struct packed {
        t_tea_word w0;
        t_tea_word w1;
    } t_tea_block;

    // ------------------------------------------------------------------------
    // Scoreboard: key copy, TEA predictor, in-order queue of expected blocks
    // ------------------------------------------------------------------------
    class cipher_checker;
        t_tea_key   key;
        t_tea_block expected_blocks[$];
        int         errors;

        function new();
            key    = '0;
            errors = 0;
        endfunction

        // Out-of-range indexes are dropped, same as the block.
        function void load_key(logic [TEA_CFG_IDX_W-1:0] index, t_tea_word data);
            case (index)
                REG_KEY0: key.k0 = data;
                REG_KEY1: key.k1 = data;
                REG_KEY2: key.k2 = data;
                REG_KEY3: key.k3 = data;
                default: ;
            endcase
        endfunction

        function t_tea_word feistel_term(t_tea_word x, t_tea_word s,
                                         t_tea_word ka, t_tea_word kb);
            return ((x << 4) + ka) ^ (x + s) ^ ((x >> 5) + kb);
        endfunction

        function t_tea_block predict_block(logic mode, t_tea_word w0, t_tea_word w1);
            t_tea_word  a;
            t_tea_word  b;
            t_tea_word  s;
            t_tea_block r;
            int         n;
            a = w0;
            b = w1;
            if (mode == MODE_ENC) begin
                s = '0;
                for (n = 0; n < TEA_CYCLES; n++) begin
                    s = s + TEA_DELTA;
                    a = a + feistel_term(b, s, key.k0, key.k1);
                    b = b + feistel_term(a, s, key.k2, key.k3);
                end
            end else begin
                // decrypt walks the cycles backward, second half first
                s = DEC_SUM_START;
                for (n = 0; n < TEA_CYCLES; n++) begin
                    b = b - feistel_term(a, s, key.k2, key.k3);
                    a = a - feistel_term(b, s, key.k0, key.k1);
                    s = s - TEA_DELTA;
                end
            end
            r.w0 = a;
            r.w1 = b;
            return r;
        endfunction

        function void note_request(logic mode, t_tea_word w0, t_tea_word w1);
            expected_blocks.push_back(predict_block(mode, w0, w1));
        endfunction

        function void check_result(t_tea_word w0, t_tea_word w1);
            t_tea_block want;
            if (expected_blocks.size() == 0) begin
                if (errors < MAX_REPORTS)
                    $display("%0t: unexpected result, actual %h %h", $time, w0, w1);
                errors++;
                return;
            end
            want = expected_blocks.pop_front();
            if (want.w0 !== w0) begin
                if (errors < MAX_REPORTS)
                    $display("%0t: out_first_word expected %h actual %h",
                             $time, want.w0, w0);
                errors++;
            end
            if (want.w1 !== w1) begin
                if (errors < MAX_REPORTS)
                    $display("%0t: out_second_word expected %h actual %h",
                             $time, want.w1, w1);
                errors++;
            end
        endfunction

        function int pending();
            return expected_blocks.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, channels, DUT
    // ------------------------------------------------------------------------
    logic clk = 1'b0;
    logic rst_n;

    int   tx_idle_pct;      // sender: chance in 100 of an idle cycle before a request
    int   rx_idle_pct;      // receiver: chance in 100 of ready low in a cycle
    int   quiet_cycles;

    cipher_checker tracker = new();

    tea_in_if  blk_in();
    tea_out_if blk_out();
    tea_cfg_if key_cfg();

    tea_block_cipher i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (blk_in),
        .o_out   (blk_out),
        .i_cfg   (key_cfg)
    );

    always begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // Receiver back-pressure, redrawn every cycle.
    always @(negedge clk) begin
        blk_out.ready = ($urandom_range(99) >= rx_idle_pct);
    end

    // Monitors: key writes, accepted requests, returned blocks.
    always @(posedge clk) begin
        if (rst_n) begin
            if (key_cfg.valid && key_cfg.ready)
                tracker.load_key(key_cfg.index, key_cfg.data);
            if (blk_in.valid && blk_in.ready)
                tracker.note_request(blk_in.mode, blk_in.first_word, blk_in.second_word);
            if (blk_out.valid && blk_out.ready)
                tracker.check_result(blk_out.out_first_word, blk_out.out_second_word);
        end
    end

    // Watchdog: any handshake restarts the count.
    always @(posedge clk) begin
        if (!rst_n || (key_cfg.valid && key_cfg.ready) || (blk_in.valid && blk_in.ready)
            || (blk_out.valid && blk_out.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: watchdog, no handshake for %0d cycles", $time, quiet_cycles);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Drivers. All called and returning at a falling edge; valid is left high
    // after a request so back-to-back requests need no toggle.
    // ------------------------------------------------------------------------
    task automatic send_block(input logic mode, input t_tea_word w0, input t_tea_word w1);
        while ($urandom_range(99) < tx_idle_pct) begin
            blk_in.valid = 1'b0;
            @(negedge clk);
        end
        blk_in.valid       = 1'b1;
        blk_in.mode        = mode;
        blk_in.first_word  = w0;
        blk_in.second_word = w1;
        do @(posedge clk); while (!blk_in.ready);
        @(negedge clk);
    endtask

    task automatic write_key(input logic [TEA_CFG_IDX_W-1:0] index, input t_tea_word data);
        key_cfg.valid = 1'b1;
        key_cfg.index = index;
        key_cfg.data  = data;
        do @(posedge clk); while (!key_cfg.ready);
        @(negedge clk);
    endtask

    // Sender holds off until every block in flight has come back.
    task automatic wait_drained();
        blk_in.valid = 1'b0;
        while (tracker.pending() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic load_keys(input t_tea_word k0, input t_tea_word k1,
                             input t_tea_word k2, input t_tea_word k3);
        wait_drained();
        write_key(REG_KEY0, k0);
        write_key(REG_KEY1, k1);
        write_key(REG_KEY2, k2);
        write_key(REG_KEY3, k3);
        // an ignored write now and then; it must leave the key alone
        if ($urandom_range(2) == 0)
            write_key(TEA_CFG_IDX_W'($urandom_range(255, 4)), $urandom());
        key_cfg.valid = 1'b0;
    endtask

    function automatic t_tea_word rand_word();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            2: return t_tea_word'(1) << $urandom_range(31);
            3: return ~(t_tea_word'(1) << $urandom_range(31));
            default: return $urandom();
        endcase
    endfunction

    function automatic t_tea_word rand_key_word();
        case ($urandom_range(3))
            0: return '0;
            1: return '1;
            default: return $urandom();
        endcase
    endfunction

    task automatic run_random(input int count);
        t_tea_block peer;
        logic       mode;
        t_tea_word  w0;
        t_tea_word  w1;
        for (int i = 0; i < count; i++) begin
            mode = 1'($urandom_range(1));
            w0   = rand_word();
            w1   = rand_word();
            // round trip: feed the other direction's output back in
            if ($urandom_range(4) == 0) begin
                peer = tracker.predict_block(~mode, w0, w1);
                w0   = peer.w0;
                w1   = peer.w1;
            end
            send_block(mode, w0, w1);
            if ($urandom_range(99) == 0)
                wait_drained();
        end
        blk_in.valid = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        rst_n               = 1'b0;
        blk_in.valid        = 1'b0;
        blk_in.mode         = MODE_ENC;
        blk_in.first_word   = '0;
        blk_in.second_word  = '0;
        blk_out.ready       = 1'b0;
        key_cfg.valid       = 1'b0;
        key_cfg.index       = REG_KEY0;
        key_cfg.data        = '0;
        tx_idle_pct         = 0;
        rx_idle_pct         = 0;
        quiet_cycles        = 0;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: reset key (all zero), word extremes, both directions.
        send_block(MODE_ENC, '0, '0);
        send_block(MODE_DEC, '0, '0);
        send_block(MODE_ENC, '1, '1);
        send_block(MODE_DEC, '1, '1);
        send_block(MODE_ENC, 32'hAAAA_AAAA, 32'h5555_5555);
        send_block(MODE_DEC, 32'h5555_5555, 32'hAAAA_AAAA);

        // All-ones key.
        load_keys('1, '1, '1, '1);
        send_block(MODE_ENC, '0, '1);
        send_block(MODE_DEC, '1, '0);
        send_block(MODE_ENC, '1, '1);
        send_block(MODE_DEC, '0, '0);

        // Classic test key, mixed halves.
        load_keys(32'h0123_4567, 32'h89AB_CDEF, 32'hFEDC_BA98, 32'h7654_3210);
        send_block(MODE_ENC, 32'h0123_4567, 32'h89AB_CDEF);
        send_block(MODE_DEC, 32'h0123_4567, 32'h89AB_CDEF);
        send_block(MODE_ENC, 32'h8000_0000, 32'h0000_0001);
        send_block(MODE_DEC, 32'h0000_0001, 32'h8000_0000);

        // Out-of-range indexes must not touch the key.
        wait_drained();
        write_key(TEA_CFG_IDX_W'(4), 32'hDEAD_BEEF);
        write_key('1, 32'hFFFF_FFFF);
        key_cfg.valid = 1'b0;
        send_block(MODE_ENC, 32'h0123_4567, 32'h89AB_CDEF);
        send_block(MODE_DEC, '1, '0);

        // Random part: three stall profiles, key changed per chunk.
        for (int phase = 0; phase < 3; phase++) begin
            wait_drained();
            case (phase)
                0: begin tx_idle_pct = 9;  rx_idle_pct = 74; end
                1: begin tx_idle_pct = 74; rx_idle_pct = 9;  end
                default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
            endcase
            for (int chunk = 0; chunk < CHUNKS / 3; chunk++) begin
                load_keys(rand_key_word(), rand_key_word(), rand_key_word(),
                          rand_key_word());
                run_random(RANDOM_BLOCKS / CHUNKS);
            end
        end

        // Drain, then let the pipeline run empty for a while.
        blk_in.valid = 1'b0;
        while (tracker.pending() != 0) @(negedge clk);
        repeat (DRAIN_TAIL) @(negedge clk);

        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
